@@ sv/cfq_pkg.sv @@
// Package for the circular FIFO queue: request and result payload types,
// request and status codes, the controller state type and shared constants.
// Depends on nothing; every other file of the block imports it.
package cfq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ELEM_BITS     = 32;
    localparam int CNT_W         = 5;
    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ       = 3'd0,
        REQ_DEQ       = 3'd1,
        REQ_PEEK_HEAD = 3'd2,
        REQ_PEEK_TAIL = 3'd3,
        REQ_CLEAR     = 3'd4
    } cfq_req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } cfq_status_t;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [ELEM_BITS-1:0] push_value;
    } cfq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ELEM_BITS-1:0] read_value;
        logic [CNT_W-1:0]     fill_count;
        logic                 is_empty_flag;
        logic                 is_full_flag;
    } cfq_result_t;

    typedef struct packed {
        logic exec;
        logic cfg_we;
    } cfq_cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } cfq_state_t;

endpackage

@@ sv/cfq_ctrl.sv @@
// Controller of the circular FIFO queue: request acceptance, result strobe
// and configuration handshake. Depends on cfq_pkg.
module cfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output logic              busy,
    output logic              done,
    output cfq_pkg::cfq_cmd_t cmd
);
    import cfq_pkg::*;

    cfq_state_t state_reg;
    cfq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        done       = 1'b0;
        cfg_ready  = 1'b0;
        cmd.exec   = 1'b0;
        cmd.cfg_we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready  = !start;
                cmd.exec   = start;
                cmd.cfg_we = cfg_valid && !start;
            end
            ST_RESP:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result strobe without an accepted request");

    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request gave no result");

    a_no_back_to_back_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

@@ sv/cfq_datapath.sv @@
// Datapath of the circular FIFO queue: entry memory, head, tail and count
// registers, capacity register and the result register. Depends on cfq_pkg.
module cfq_datapath #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfq_pkg::cfq_cmd_t           cmd,
    input  cfq_pkg::cfq_req_t           request,
    input  logic [cfq_pkg::CNT_W-1:0]   cfg_data,
    output cfq_pkg::cfq_result_t        result
);
    import cfq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CMP_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int CAP_MAX = (DEPTH < (2 ** CNT_W) - 1) ? DEPTH : (2 ** CNT_W) - 1;

    logic [ELEM_BITS-1:0] mem [DEPTH];

    logic [CNT_W-1:0]     cap_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [ELEM_BITS-1:0] rd_data_reg;
    logic                 rd_en_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 empty_reg;
    logic                 full_reg;

    logic [CNT_W-1:0]     cap_live;
    logic [IDX_W-1:0]     tail_prev;
    logic [IDX_W-1:0]     rd_addr;
    logic                 rd_en;
    logic                 mem_we;
    logic [STATUS_W-1:0]  status_next;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(idx) + CMP_W'(1);
        return (inc >= CMP_W'(cap)) ? '0 : IDX_W'(inc);
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_live = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(CAP_MAX))
        begin
            cap_live = CNT_W'(CAP_MAX);
        end
        else
        begin
            cap_live = cap_reg;
        end
    end

    always_comb
    begin
        tail_prev   = (tail_reg == '0) ? IDX_W'(CMP_W'(cap_live) - CMP_W'(1))
                                       : tail_reg - IDX_W'(1);
        rd_addr     = (request.req_type == REQ_PEEK_TAIL) ? tail_prev : head_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        status_next = STAT_DONE;
        unique case (request.req_type) inside
            REQ_ENQ:
            begin
                if (count_reg >= cap_live)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    tail_next  = advance(tail_reg, cap_live);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DEQ, REQ_PEEK_HEAD, REQ_PEEK_TAIL:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                    if (request.req_type == REQ_DEQ)
                    begin
                        head_next  = advance(head_reg, cap_live);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            REQ_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.cfg_we)
        begin
            cap_reg   <= cfg_data;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[tail_reg] <= request.push_value;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_en_reg  <= rd_en;
            status_reg <= status_next;
            fill_reg   <= count_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= (count_next >= cap_live);
        end
    end

    always_comb
    begin
        result.status        = status_reg;
        result.read_value    = rd_en_reg ? rd_data_reg : '0;
        result.fill_count    = fill_reg;
        result.is_empty_flag = empty_reg;
        result.is_full_flag  = full_reg;
    end

    a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_live)
        else $error("entry count exceeds live capacity");

    a_head_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(head_reg) < CMP_W'(cap_live))
        else $error("head index outside the ring");

    a_tail_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(tail_reg) < CMP_W'(cap_live))
        else $error("tail index outside the ring");

endmodule

@@ sv/circular_fifo_queue.sv @@
// Top level of the circular FIFO queue: joins the controller and datapath.
// Depends on cfq_pkg, cfq_ctrl and cfq_datapath.
//
//   Channel   Handshake              Payload
//   request   start, busy            request (cfq_req_t)
//   result    done (one-cycle)       result (cfq_result_t)
//   config    cfg_valid, cfg_ready   cfg_data (queue capacity)
//
// Each request is accepted, the entry memory is written or read at that
// edge, and the result is shown for one cycle with done while busy is high.
// The memory read is registered, and the result with it.
// Reset clears head, tail and count and sets the capacity to 16.
// The result side cannot stall; the request side waits on busy.
module circular_fifo_queue #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cfq_pkg::cfq_req_t           request,
    output logic                        done,
    output cfq_pkg::cfq_result_t        result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cfq_pkg::CNT_W-1:0]   cfg_data
);
    import cfq_pkg::*;

    cfq_cmd_t cmd;

    cfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    cfq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule
